>>> hdl/psmma_pkg.sv
// psmma_pkg: shared constants and controller/datapath command types for the
// per-second min/max/average block. No dependencies.
package psmma_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 10;
    localparam int SECOND_BITS = 32;
    localparam int AVG_BITS    = 18;

    // parameter defaults
    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // reset value of the minimum restart register
    localparam logic [SAMPLE_BITS-1:0] LOWEST_START_RST = 10'd512;

    // saturation value of the latched average
    localparam logic [AVG_BITS-1:0] AVG_MAX = {AVG_BITS{1'b1}};

    // controller to datapath commands
    typedef struct packed {
        logic take;     // accept the input word into the accumulators
        logic step;     // one restoring division step
        logic finish;   // latch average, min and max of the closed window
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic closes;   // the presented word closes the window
        logic div_last; // the division is on its final step
    } t_dp_status;

endpackage

>>> hdl/psmma_if.sv
// psmma_in_if / psmma_out_if: valid/ready channels for input and result words.
// Depends on psmma_pkg for field widths.
interface psmma_in_if;
    logic                                valid;
    logic                                ready;
    logic [psmma_pkg::SAMPLE_BITS-1:0]   sample;
    logic [psmma_pkg::SECOND_BITS-1:0]   seconds;

    modport source (output valid, output sample, output seconds, input ready);
    modport sink   (input valid, input sample, input seconds, output ready);
endinterface

interface psmma_out_if;
    logic                                valid;
    logic                                ready;
    logic [psmma_pkg::AVG_BITS-1:0]      average_q8;
    logic [psmma_pkg::SAMPLE_BITS-1:0]   lowest;
    logic [psmma_pkg::SAMPLE_BITS-1:0]   highest;
    logic                                window_closed;

    modport source (output valid, output average_q8, output lowest, output highest,
                    output window_closed, input ready);
    modport sink   (input valid, input average_q8, input lowest, input highest,
                    input window_closed, output ready);
endinterface

>>> hdl/psmma_dp.sv
// psmma_dp: accumulators, window latches, config register and the
// bit-serial restoring divider. Depends on psmma_pkg.
module psmma_dp #(
    parameter int COUNT_BITS    = psmma_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = psmma_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psmma_pkg::SAMPLE_BITS-1:0]   i_cfg_wdata,
    input  logic [psmma_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic [psmma_pkg::SECOND_BITS-1:0]   i_seconds,
    input  psmma_pkg::t_dp_cmd                  i_cmd,
    output psmma_pkg::t_dp_status               o_status,
    output logic [psmma_pkg::AVG_BITS-1:0]      o_average_q8,
    output logic [psmma_pkg::SAMPLE_BITS-1:0]   o_lowest,
    output logic [psmma_pkg::SAMPLE_BITS-1:0]   o_highest
);
    localparam int SB        = psmma_pkg::SAMPLE_BITS;
    localparam int SUM_BITS  = SB + COUNT_BITS;
    localparam int DIV_BITS  = SUM_BITS + FRACTION_BITS;
    localparam int STEP_BITS = $clog2(DIV_BITS);

    logic [SB-1:0]                      r_lowest_start;
    logic [SUM_BITS-1:0]                r_sum;
    logic [COUNT_BITS-1:0]              r_count;
    logic [SB-1:0]                      r_min;
    logic [SB-1:0]                      r_max;
    logic [psmma_pkg::SECOND_BITS-1:0]  r_last;
    logic [DIV_BITS-1:0]                r_dvd;
    logic [COUNT_BITS-1:0]              r_dvs;
    logic [COUNT_BITS-1:0]              r_rem;
    logic [STEP_BITS-1:0]               r_step;
    logic [SB-1:0]                      r_pend_min;
    logic [SB-1:0]                      r_pend_max;
    logic [psmma_pkg::AVG_BITS-1:0]     r_avg;
    logic [SB-1:0]                      r_lo;
    logic [SB-1:0]                      r_hi;

    logic [psmma_pkg::SECOND_BITS-1:0]  last_eff;
    logic                               closes;
    logic [SB-1:0]                      cur_min;
    logic [SB-1:0]                      cur_max;
    logic [SUM_BITS:0]                  sum_ext;
    logic [SUM_BITS-1:0]                sum_new;
    logic [COUNT_BITS-1:0]              count_new;
    logic [SB-1:0]                      min_new;
    logic [SB-1:0]                      max_new;
    logic [COUNT_BITS:0]                rem_sh;
    logic [COUNT_BITS:0]                rem_diff;
    logic                               fits;
    logic [psmma_pkg::AVG_BITS-1:0]     q_sat;

    // window bookkeeping for the presented word
    always_comb begin
        last_eff  = (r_last == '0) ? i_seconds : r_last;
        closes    = (i_seconds != last_eff);
        cur_min   = (r_count == '0) ? r_lowest_start : r_min;
        cur_max   = (r_count == '0) ? '0 : r_max;
        sum_ext   = {1'b0, r_sum} + (SUM_BITS + 1)'(i_sample);
        sum_new   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
        count_new = (&r_count) ? r_count : r_count + 1'b1;
        min_new   = (i_sample < cur_min) ? i_sample : cur_min;
        max_new   = (i_sample > cur_max) ? i_sample : cur_max;
    end

    // one restoring division step, quotient bits shift in behind the dividend
    always_comb begin
        rem_sh   = {r_rem, r_dvd[DIV_BITS-1]};
        rem_diff = rem_sh - {1'b0, r_dvs};
        fits     = (rem_sh >= {1'b0, r_dvs});
        q_sat    = (r_dvd > DIV_BITS'(psmma_pkg::AVG_MAX)) ? psmma_pkg::AVG_MAX
                                                           : r_dvd[psmma_pkg::AVG_BITS-1:0];
    end

    assign o_status.closes   = closes;
    assign o_status.div_last = (r_step == STEP_BITS'(DIV_BITS - 1));

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest_start <= psmma_pkg::LOWEST_START_RST;
        end else if (i_cfg_we) begin
            r_lowest_start <= i_cfg_wdata;
        end
    end

    // accumulators and timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_last  <= '0;
        end else if (i_cmd.take) begin
            r_last <= i_seconds;
            if (closes) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= sum_new;
                r_count <= count_new;
                r_last  <= last_eff;
            end
        end
    end

    // running extremes, only meaningful while the count is nonzero
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_min      <= min_new;
            r_max      <= max_new;
            r_pend_min <= min_new;
            r_pend_max <= max_new;
        end
    end

    // divider: load on every accepted word, then one bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dvd  <= DIV_BITS'(sum_new) << FRACTION_BITS;
            r_dvs  <= count_new;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.step) begin
            r_dvd  <= {r_dvd[DIV_BITS-2:0], fits};
            r_rem  <= fits ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    // window latches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else if (i_cmd.finish) begin
            r_avg <= q_sat;
            r_lo  <= r_pend_min;
            r_hi  <= r_pend_max;
        end
    end

    assign o_average_q8 = r_avg;
    assign o_lowest     = r_lo;
    assign o_highest    = r_hi;

endmodule

>>> hdl/psmma_ctrl.sv
// psmma_ctrl: sequencing of accept, division and result handoff.
// Depends on psmma_pkg for the command and status types.
module psmma_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_window_closed,
    input  psmma_pkg::t_dp_status   i_status,
    output psmma_pkg::t_dp_cmd      o_cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       r_closed;
    logic       take;

    // accept only when idle and the result slot is free or being freed
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;

    assign o_cmd.take   = take;
    assign o_cmd.step   = (r_state == ST_DIV);
    assign o_cmd.finish = (r_state == ST_DONE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take && i_status.closes) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_closed    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take && !i_status.closes) begin
                r_out_valid <= 1'b1;
                r_closed    <= 1'b0;
            end else if (r_state == ST_DONE) begin
                r_out_valid <= 1'b1;
                r_closed    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_window_closed = r_closed;

endmodule

>>> hdl/per_second_min_max_average.sv
// per_second_min_max_average: top level joining controller and datapath.
// Depends on psmma_pkg, psmma_if, psmma_ctrl and psmma_dp.
//
// Usage:
//   i_in carries words of {sample, seconds}; o_out returns one result word
//   {average_q8, lowest, highest, window_closed} for every input word.
//   i_cfg_we/i_cfg_wdata write the value the running minimum restarts from.
//   A word whose seconds differ from the stored second closes the window:
//   the average (sum over count, FRACTION_BITS fraction bits, truncated and
//   saturated) is found by a restoring divider, one quotient bit per cycle.
//   A word that closes no window shows its result in the cycle after accept;
//   a closing word shows its result after the 10 + COUNT_BITS + FRACTION_BITS
//   division steps in ST_DIV and the result latch in ST_DONE.
//   Throughput is one word per cycle while no window closes and results are
//   taken; a closing word holds off input while the single shared divider works.
//   A result waiting in the output slot does not block the next input word
//   as long as the receiver takes it in the same cycle; while the receiver
//   stalls the result holds and input ready stays low.
//   Reset clears the accumulators, latches and stored second and sets the
//   restart value to 512; no clearing pass is needed.
module per_second_min_max_average #(
    parameter int COUNT_BITS    = psmma_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = psmma_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psmma_pkg::SAMPLE_BITS-1:0]   i_cfg_wdata,
    psmma_in_if.sink                            i_in,
    psmma_out_if.source                         o_out
);
    psmma_pkg::t_dp_cmd    cmd;
    psmma_pkg::t_dp_status status;

    // sequencing
    psmma_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .o_in_ready      (i_in.ready),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_window_closed (o_out.window_closed),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    // arithmetic and state
    psmma_dp #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_in.sample),
        .i_seconds    (i_in.seconds),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_average_q8 (o_out.average_q8),
        .o_lowest     (o_out.lowest),
        .o_highest    (o_out.highest)
    );

endmodule
